[hdl/wcsp_pkg.sv]
// Shared types, constants and the arctangent table for the cross-spectrum phase unit.
`default_nettype none

package wcsp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FREQ_W     = 32;
    localparam int BINW_W     = 24;
    localparam int PHASE_W    = 16;
    localparam int ANG_W      = 14;
    localparam int Z_W        = 27;
    localparam int ATAN_W     = 25;
    localparam int CNT_W      = 5;
    localparam int ATAN_LEN   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_EDGE     = 2'd3;

    localparam logic signed [PHASE_W-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [Z_W-1:0]     HALF_PI_Q24 = 27'sd26353589;
    localparam logic signed [Z_W-1:0]     ROUND_Q24   = 27'sd1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CLASS,
        S_NORM,
        S_ROT,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        OP_HRLR,
        OP_HILI,
        OP_HILR,
        OP_HRLI
    } t_mop;

    typedef struct packed {
        logic mul;
        t_mop mul_op;
        logic acc;
        t_mop acc_op;
    } t_cross_ctl;

    typedef struct packed {
        logic             load;
        logic             norm;
        logic             rot;
        logic [CNT_W-1:0] step;
    } t_cordic_ctl;

    function automatic logic [ATAN_W-1:0] atan_q24(input logic [CNT_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 25'd13176795;
            5'd1:    v = 25'd7778716;
            5'd2:    v = 25'd4110060;
            5'd3:    v = 25'd2086331;
            5'd4:    v = 25'd1047214;
            5'd5:    v = 25'd524117;
            5'd6:    v = 25'd262123;
            5'd7:    v = 25'd131069;
            5'd8:    v = 25'd65536;
            5'd9:    v = 25'd32768;
            5'd10:   v = 25'd16384;
            5'd11:   v = 25'd8192;
            5'd12:   v = 25'd4096;
            5'd13:   v = 25'd2048;
            5'd14:   v = 25'd1024;
            5'd15:   v = 25'd512;
            5'd16:   v = 25'd256;
            5'd17:   v = 25'd128;
            5'd18:   v = 25'd64;
            5'd19:   v = 25'd32;
            5'd20:   v = 25'd16;
            5'd21:   v = 25'd8;
            5'd22:   v = 25'd4;
            5'd23:   v = 25'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/windowed_cross_spectrum_phase_unit.sv]
// Top level: configuration, bin frequency, sequencer and output word register.
//
//   channel  direction  handshake                   payload
//   bin in   in         i_in_valid / o_in_stall     i_high_re i_high_im i_low_re i_low_im
//                                                   i_bin_last
//   result   out        o_out_valid / i_out_stall   o_freq_hz o_phase o_in_window
//                                                   o_frame_last
//   config   in         i_cfg_we                    i_cfg_index i_cfg_data
//
// An in-window bin passes through the multiply, classify, normalize and rotate states before the
// result register is loaded, with N = min(CORDIC_STEPS, 24) CORDIC iterations; the last normalizing
// step loads the CORDIC, and the shared multiplier forms four products. Bins outside the window go
// straight to the final state; bins with a zero or real cross product skip normalizing and rotation.
// A stalled result holds the block in its final cycle; one new word is taken while a result waits.
// Synchronous active-low reset clears configuration, frequency and control.
`default_nettype none

module windowed_cross_spectrum_phase_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        i_cfg_we,
    input  wire logic [wcsp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [wcsp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                        i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        i_high_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        i_high_im,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        i_low_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0]        i_low_im,
    input  wire                                        i_bin_last,
    output logic                                       o_out_valid,
    input  wire                                        i_out_stall,
    output logic [wcsp_pkg::FREQ_W-1:0]                o_freq_hz,
    output logic signed [wcsp_pkg::PHASE_W-1:0]        o_phase,
    output logic                                       o_in_window,
    output logic                                       o_frame_last
);
    import wcsp_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int MAG_W  = 2 * SAMPLE_WIDTH;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    logic                r_win_en;
    logic [BINW_W-1:0]   r_bin_width;
    logic [FREQ_W-1:0]   r_low_edge, r_high_edge;
    logic [FREQ_W-1:0]   r_acc;
    logic [FREQ_W-1:0]   r_freq_cur;
    logic                r_inwin, r_last;
    logic                r_all_zero, r_im_zero;

    logic                w_accept, w_inwin_now, w_out_free, w_load_out;
    logic [FREQ_W:0]     w_freq_sum;
    logic [FREQ_W-1:0]   w_freq_next;

    t_cross_ctl          w_xctl;
    t_cordic_ctl         w_cctl;
    logic                w_xload;
    logic [MAG_W-1:0]    w_re_mag, w_im_mag;
    logic                w_re_neg, w_im_neg;
    logic                w_norm_done;
    logic [ANG_W-1:0]    w_angle;

    logic signed [PHASE_W-1:0] w_pa, w_ps, w_phase;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_free  = !o_out_valid || !i_out_stall;
    assign w_load_out  = (r_state == S_FIN) && w_out_free;
    assign w_inwin_now = r_win_en && (r_acc >= r_low_edge) && (r_acc <= r_high_edge);
    assign w_freq_sum  = {1'b0, r_acc} + (FREQ_W + 1)'(r_bin_width);
    assign w_freq_next = w_freq_sum[FREQ_W] ? '1 : w_freq_sum[FREQ_W-1:0];

    wcsp_cross #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cross (
        .i_clk     (i_clk),
        .i_load    (w_xload),
        .i_high_re (i_high_re),
        .i_high_im (i_high_im),
        .i_low_re  (i_low_re),
        .i_low_im  (i_low_im),
        .i_ctl     (w_xctl),
        .o_re_mag  (w_re_mag),
        .o_im_mag  (w_im_mag),
        .o_re_neg  (w_re_neg),
        .o_im_neg  (w_im_neg)
    );

    wcsp_cordic #(
        .MAG_W (MAG_W)
    ) u_cordic (
        .i_clk       (i_clk),
        .i_ctl       (w_cctl),
        .i_x_mag     (w_re_mag),
        .i_y_mag     (w_im_mag),
        .o_norm_done (w_norm_done),
        .o_angle     (w_angle)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_inwin_now ? S_MUL : S_FIN;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(4)) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (w_im_mag == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (w_norm_done) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (r_cnt == CNT_W'(NSTEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt          = '0;
        w_xload        = 1'b0;
        w_xctl.mul     = 1'b0;
        w_xctl.mul_op  = t_mop'(r_cnt[1:0]);
        w_xctl.acc     = 1'b0;
        w_xctl.acc_op  = t_mop'(r_cnt[1:0] - 2'd1);
        w_cctl.load    = 1'b0;
        w_cctl.norm    = 1'b0;
        w_cctl.rot     = 1'b0;
        w_cctl.step    = r_cnt;
        case (r_state)
            S_IDLE: begin
                w_xload = w_accept;
            end
            S_MUL: begin
                n_cnt      = r_cnt + CNT_W'(1);
                w_xctl.mul = (r_cnt != CNT_W'(4));
                w_xctl.acc = (r_cnt != CNT_W'(0));
            end
            S_CLASS: begin
                w_cctl.load = 1'b1;
            end
            S_NORM: begin
                w_cctl.norm = 1'b1;
            end
            S_ROT: begin
                w_cctl.rot = 1'b1;
                n_cnt      = r_cnt + CNT_W'(1);
            end
            S_FIN: begin
                n_cnt = '0;
            end
            default: n_cnt = '0;
        endcase
    end

    always_comb begin
        w_pa = w_re_neg ? (PI_Q13 - $signed({2'b00, w_angle}))
                        : $signed({2'b00, w_angle});
        w_ps = w_im_neg ? -w_pa : w_pa;
        if (!r_inwin || r_all_zero) begin
            w_phase = '0;
        end else if (r_im_zero) begin
            w_phase = w_re_neg ? PI_Q13 : '0;
        end else if (w_ps == -PI_Q13) begin
            w_phase = PI_Q13;
        end else begin
            w_phase = w_ps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_win_en    <= 1'b0;
            r_bin_width <= '0;
            r_low_edge  <= '0;
            r_high_edge <= '0;
            r_acc       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_ENABLE: r_win_en    <= i_cfg_data[0];
                    CFG_BIN_WIDTH:     r_bin_width <= i_cfg_data[BINW_W-1:0];
                    CFG_LOW_EDGE:      r_low_edge  <= i_cfg_data;
                    CFG_HIGH_EDGE:     r_high_edge <= i_cfg_data;
                    default:           r_win_en    <= r_win_en;
                endcase
            end
            if (w_accept) begin
                r_acc <= i_bin_last ? '0 : w_freq_next;
            end
            if (w_load_out) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_freq_cur <= r_acc;
            r_inwin    <= w_inwin_now;
            r_last     <= i_bin_last;
        end
        if (r_state == S_CLASS) begin
            r_all_zero <= (w_re_mag == '0) && (w_im_mag == '0);
            r_im_zero  <= (w_im_mag == '0);
        end
        if (w_load_out) begin
            o_freq_hz    <= r_freq_cur;
            o_phase      <= w_phase;
            o_in_window  <= r_inwin;
            o_frame_last <= r_last;
        end
    end

endmodule

`default_nettype wire

[hdl/wcsp_cross.sv]
// Cross product high * conj(low) over one shared multiplier, with magnitude and sign outputs.
`default_nettype none

module wcsp_cross #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                              i_clk,
    input  wire                              i_load,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_high_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_high_im,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_low_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_low_im,
    input  wire wcsp_pkg::t_cross_ctl        i_ctl,
    output logic [2*SAMPLE_WIDTH-1:0]        o_re_mag,
    output logic [2*SAMPLE_WIDTH-1:0]        o_im_mag,
    output logic                             o_re_neg,
    output logic                             o_im_neg
);
    import wcsp_pkg::*;

    localparam int PW = 2 * SAMPLE_WIDTH;
    localparam int AW = PW + 1;

    logic signed [SAMPLE_WIDTH-1:0] r_hr, r_hi, r_lr, r_li;
    logic signed [SAMPLE_WIDTH-1:0] w_a, w_b;
    logic signed [PW-1:0]           r_prod;
    logic signed [AW-1:0]           r_re, r_im;
    logic signed [AW-1:0]           w_pext;
    logic signed [AW-1:0]           w_re_abs, w_im_abs;

    always_comb begin
        case (i_ctl.mul_op)
            OP_HRLR: begin w_a = r_hr; w_b = r_lr; end
            OP_HILI: begin w_a = r_hi; w_b = r_li; end
            OP_HILR: begin w_a = r_hi; w_b = r_lr; end
            OP_HRLI: begin w_a = r_hr; w_b = r_li; end
            default: begin w_a = r_hr; w_b = r_lr; end
        endcase
    end

    assign w_pext = AW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hr <= i_high_re;
            r_hi <= i_high_im;
            r_lr <= i_low_re;
            r_li <= i_low_im;
        end
        if (i_ctl.mul) begin
            r_prod <= w_a * w_b;
        end
        if (i_ctl.acc) begin
            case (i_ctl.acc_op)
                OP_HRLR: r_re <= w_pext;
                OP_HILI: r_re <= r_re + w_pext;
                OP_HILR: r_im <= w_pext;
                OP_HRLI: r_im <= r_im - w_pext;
                default: r_re <= r_re;
            endcase
        end
    end

    assign w_re_abs = r_re[AW-1] ? -r_re : r_re;
    assign w_im_abs = r_im[AW-1] ? -r_im : r_im;
    assign o_re_mag = w_re_abs[PW-1:0];
    assign o_im_mag = w_im_abs[PW-1:0];
    assign o_re_neg = r_re[AW-1];
    assign o_im_neg = r_im[AW-1];

endmodule

`default_nettype wire

[hdl/wcsp_cordic.sv]
// Normalizing shifter and iterative vectoring CORDIC giving a first-quadrant angle.
`default_nettype none

module wcsp_cordic #(
    parameter int MAG_W = 32
) (
    input  wire                          i_clk,
    input  wire wcsp_pkg::t_cordic_ctl   i_ctl,
    input  wire logic [MAG_W-1:0]        i_x_mag,
    input  wire logic [MAG_W-1:0]        i_y_mag,
    output logic                         o_norm_done,
    output logic [wcsp_pkg::ANG_W-1:0]   o_angle
);
    import wcsp_pkg::*;

    localparam int NW = (MAG_W > 31) ? MAG_W : 31;
    localparam int XW = 33;

    logic [NW-1:0]          r_x, r_y;
    logic [NW-1:0]          w_big;
    logic signed [XW-1:0]   r_cx, r_cy;
    logic signed [XW-1:0]   w_dx, w_dy;
    logic signed [Z_W-1:0]  r_z;
    logic signed [Z_W-1:0]  w_atan;
    logic signed [Z_W-1:0]  w_zc;
    logic signed [Z_W-1:0]  w_zr;

    assign w_big       = (r_x > r_y) ? r_x : r_y;
    assign o_norm_done = ((w_big >> 30) == '0) && ((w_big >> 29) != '0);

    assign w_dx   = r_cy >>> i_ctl.step;
    assign w_dy   = r_cx >>> i_ctl.step;
    assign w_atan = $signed({2'b00, atan_q24(i_ctl.step)});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= NW'(i_x_mag);
            r_y <= NW'(i_y_mag);
        end else if (i_ctl.norm) begin
            if ((w_big >> 38) != '0) begin
                r_x <= r_x >> 8;
                r_y <= r_y >> 8;
            end else if ((w_big >> 30) != '0) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
            end else if ((w_big >> 21) == '0) begin
                r_x <= r_x << 8;
                r_y <= r_y << 8;
            end else if ((w_big >> 29) == '0) begin
                r_x <= r_x << 1;
                r_y <= r_y << 1;
            end else begin
                r_cx <= $signed({3'b000, r_x[29:0]});
                r_cy <= $signed({3'b000, r_y[29:0]});
                r_z  <= '0;
            end
        end else if (i_ctl.rot) begin
            if (!r_cy[XW-1]) begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_z  <= r_z + w_atan;
            end else begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_z  <= r_z - w_atan;
            end
        end
    end

    always_comb begin
        if (r_z[Z_W-1]) begin
            w_zc = '0;
        end else if (r_z > HALF_PI_Q24) begin
            w_zc = HALF_PI_Q24;
        end else begin
            w_zc = r_z;
        end
    end

    assign w_zr    = w_zc + ROUND_Q24;
    assign o_angle = w_zr[ANG_W+10:11];

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the windowed cross-spectrum phase unit.
`timescale 1ns / 100ps

localparam int SW    = 16;
localparam int STEPS = 16;

localparam longint ATAN_STEP_Q24 [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
};

typedef logic signed [SW-1:0] t_sample;

typedef struct packed {
    t_sample high_re;
    t_sample high_im;
    t_sample low_re;
    t_sample low_im;
    logic    last;
} t_bin;

typedef struct packed {
    logic [31:0]        freq_hz;
    logic signed [15:0] phase;
    logic               in_window;
    logic               frame_last;
} t_result;

class bin_phase_tracker;
    bit        win_en;
    bit [23:0] step_hz;
    bit [31:0] lo_hz;
    bit [31:0] hi_hz;
    bit [31:0] freq_acc;
    t_result   due_results[$];
    int        errors;
    int        words;
    int        frames;
    int        in_win;
    int        at_pi;
    int        saturated;

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            wcsp_pkg::CFG_WINDOW_ENABLE: win_en  = data[0];
            wcsp_pkg::CFG_BIN_WIDTH:     step_hz = data[23:0];
            wcsp_pkg::CFG_LOW_EDGE:      lo_hz   = data;
            wcsp_pkg::CFG_HIGH_EDGE:     hi_hz   = data;
            default: ;
        endcase
    endfunction

    function longint quadrant_angle(longint x, longint y);
        longint big;
        longint cx;
        longint cy;
        longint z;
        longint dx;
        longint dy;
        big = (x > y) ? x : y;
        while (big >= 64'sd1073741824) begin
            x = x >> 1;
            y = y >> 1;
            big = big >> 1;
        end
        while (big < 64'sd536870912) begin
            x = x << 1;
            y = y << 1;
            big = big << 1;
        end
        cx = x;
        cy = y;
        z = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + ATAN_STEP_Q24[i];
            end else begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - ATAN_STEP_Q24[i];
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(wcsp_pkg::HALF_PI_Q24)) z = longint'(wcsp_pkg::HALF_PI_Q24);
        return (z + 1024) >>> 11;
    endfunction

    function logic signed [15:0] cross_phase(t_bin b);
        longint re;
        longint im;
        longint a;
        longint p;
        longint pi_q13;
        pi_q13 = longint'(wcsp_pkg::PI_Q13);
        re = longint'(b.high_re) * longint'(b.low_re) + longint'(b.high_im) * longint'(b.low_im);
        im = longint'(b.high_im) * longint'(b.low_re) - longint'(b.high_re) * longint'(b.low_im);
        if (re == 0 && im == 0) return '0;
        if (im == 0) return (re < 0) ? wcsp_pkg::PI_Q13 : '0;
        a = quadrant_angle((re < 0) ? -re : re, (im < 0) ? -im : im);
        p = (re < 0) ? pi_q13 - a : a;
        if (im < 0) p = -p;
        if (p == -pi_q13) p = pi_q13;
        return p[15:0];
    endfunction

    function void note_bin(t_bin b);
        t_result         r;
        longint unsigned nxt;
        r.freq_hz    = freq_acc;
        r.in_window  = win_en && freq_acc >= lo_hz && freq_acc <= hi_hz;
        r.phase      = r.in_window ? cross_phase(b) : '0;
        r.frame_last = b.last;
        due_results.insert(due_results.size(), r);
        in_win    += r.in_window;
        at_pi     += (r.phase == wcsp_pkg::PI_Q13);
        saturated += (freq_acc == 32'hFFFF_FFFF);
        frames    += b.last;
        nxt = 64'(freq_acc) + 64'(step_hz);
        if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
        freq_acc = b.last ? 32'd0 : nxt[31:0];
    endfunction

    function void check_word(t_result got);
        t_result want;
        words++;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result: freq %h phase %0d win %b last %b",
                     $time, got.freq_hz, got.phase, got.in_window, got.frame_last);
            errors++;
            return;
        end
        want = due_results.pop_front();
        if (got !== want) begin
            $display("%0t: mismatch: expected freq %h phase %0d win %b last %b",
                     $time, want.freq_hz, want.phase, want.in_window, want.frame_last);
            $display("%0t:           actual   freq %h phase %0d win %b last %b",
                     $time, got.freq_hz, got.phase, got.in_window, got.frame_last);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_sample     high_re   = '0;
    t_sample     high_im   = '0;
    t_sample     low_re    = '0;
    t_sample     low_im    = '0;
    logic        bin_last  = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] freq_hz;
    logic signed [15:0] phase;
    logic        in_window;
    logic        frame_last;

    int send_idle_pct = 23;
    int recv_idle_pct = 54;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    bin_phase_tracker sb = new();

    windowed_cross_spectrum_phase_unit #(
        .SAMPLE_WIDTH(SW),
        .CORDIC_STEPS(STEPS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_high_re   (high_re),
        .i_high_im   (high_im),
        .i_low_re    (low_re),
        .i_low_im    (low_im),
        .i_bin_last  (bin_last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_freq_hz   (freq_hz),
        .o_phase     (phase),
        .o_in_window (in_window),
        .o_frame_last(frame_last)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_word(t_result'{freq_hz, phase, in_window, frame_last});
        end
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_bin(t_bin b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        high_re  <= b.high_re;
        high_im  <= b.high_im;
        low_re   <= b.low_re;
        low_im   <= b.low_im;
        bin_last <= b.last;
        do @(posedge clk); while (in_stall);
        sb.note_bin(b);
    endtask

    task automatic send_fields(int hr, int hi, int lr, int li, bit last);
        t_bin b;
        b.high_re = t_sample'(hr);
        b.high_im = t_sample'(hi);
        b.low_re  = t_sample'(lr);
        b.low_im  = t_sample'(li);
        b.last    = last;
        send_bin(b);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_window(bit en, logic [31:0] step, logic [31:0] lo, logic [31:0] hi);
        write_reg(wcsp_pkg::CFG_WINDOW_ENABLE, ($urandom() & 32'hFFFF_FFFE) | en);
        write_reg(wcsp_pkg::CFG_BIN_WIDTH, step);
        write_reg(wcsp_pkg::CFG_LOW_EDGE, lo);
        write_reg(wcsp_pkg::CFG_HIGH_EDGE, hi);
        cfg_we <= 1'b0;
    endtask

    function automatic t_sample corner_value();
        case ($urandom_range(4))
            0:       return t_sample'(0);
            1:       return t_sample'(1);
            2:       return t_sample'(-1);
            3:       return t_sample'(32767);
            default: return t_sample'(-32768);
        endcase
    endfunction

    function automatic t_bin rand_bin(bit last);
        t_bin b;
        int   a;
        int   c;
        int   s;
        a = int'($urandom_range(65534)) - 32767;
        c = int'($urandom_range(65534)) - 32767;
        s = $urandom_range(1) ? 1 : -1;
        case ($urandom_range(9))
            6, 7: begin
                b.high_re = corner_value();
                b.high_im = corner_value();
                b.low_re  = corner_value();
                b.low_im  = corner_value();
            end
            8: begin
                // real-axis product: zero or pi
                b.high_re = t_sample'(a);
                b.high_im = t_sample'(c);
                b.low_re  = t_sample'(s * a);
                b.low_im  = t_sample'(s * c);
            end
            9: begin
                // imaginary-axis product: plus or minus half pi
                b.high_re = t_sample'(a);
                b.high_im = t_sample'(c);
                b.low_re  = t_sample'(s * c);
                b.low_im  = t_sample'(-s * a);
            end
            default: {b.high_re, b.high_im, b.low_re, b.low_im} = {$urandom(), $urandom()};
        endcase
        b.last = last;
        return b;
    endfunction

    task automatic run_phase(bit en, logic [31:0] step, logic [31:0] lo, logic [31:0] hi,
                             int count, int min_frame, int max_frame, bit hold);
        int run;
        wait_idle();
        program_window(en, step, lo, hi);
        if (hold) hold_reqs++;
        run = $urandom_range(max_frame, min_frame);
        for (int n = 0; n < count; n++) begin
            run--;
            send_bin(rand_bin(run == 0));
            if (run == 0) run = $urandom_range(max_frame, min_frame);
        end
    endtask

    initial begin
        logic [31:0] w;
        logic [31:0] lo;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_window(1'b1, 32'h100, 32'h0, 32'hFFFF_FFFF);
        send_fields(0, 0, 0, 0, 1'b0);
        send_fields(-1, 0, 1, 0, 1'b0);
        send_fields(0, 1, 1, 0, 1'b0);
        send_fields(0, -1, 1, 0, 1'b0);
        send_fields(-32768, 0, 32767, -1, 1'b1);
        send_fields(32767, 32767, 32767, 32767, 1'b0);
        send_fields(-32768, -32768, -32768, -32768, 1'b0);
        send_fields(-32768, -32768, 32767, 32767, 1'b0);
        send_fields(-32768, 32767, 32767, -32768, 1'b0);
        send_fields(32767, -32768, -32768, 32767, 1'b0);
        send_fields(1, 0, 0, -32768, 1'b0);
        send_fields(-32768, 1, -1, -32768, 1'b0);
        send_fields(100, 0, 0, 0, 1'b0);
        send_fields(5, -3, -7, 2, 1'b1);
        send_fields(32767, 0, 32767, 1, 1'b0);
        send_fields(-32768, 0, -32768, 0, 1'b0);
        send_fields(1, 1, 1, -1, 1'b1);
        send_fields(-21846, 21845, -1, -32768, 1'b0);

        // sender 23 / receiver 54
        run_phase(1'b1, 32'd1000, 32'd3000, 32'd7000, 160, 1, 12, 1'b0);
        run_phase(1'b0, $urandom(), 32'h0, 32'hFFFF_FFFF, 120, 1, 16, 1'b0);
        run_phase(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 300, 280, 300, 1'b0);

        send_idle_pct = 54;
        recv_idle_pct = 23;
        run_phase(1'b1, $urandom_range(2048, 1), 32'h2000, 32'h1FFF, 120, 1, 20, 1'b0);
        run_phase(1'b1, 32'h0, 32'h0, 32'h0, 120, 1, 24, 1'b0);
        w  = $urandom_range(5000, 1);
        lo = w * $urandom_range(4);
        run_phase(1'b1, w, lo, lo + w * $urandom_range(8), 150, 1, 16, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(1'b1, 32'd256, 32'h0, 32'hFFFF_FFFF, 200, 4, 24, 1'b1);
        run_phase($urandom_range(1), $urandom(), $urandom(), $urandom(), 120, 1, 24, 1'b0);

        wait_idle();
        $display("Checked %0d results over %0d frames: %0d in window, %0d at +pi, %0d saturated.",
                 sb.words, sb.frames, sb.in_win, sb.at_pi, sb.saturated);
        $display("Swept window on/off, inverted and point edges, bin width zero to max, %0d-cycle hold.",
                 HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("windowed_cross_spectrum_phase_unit test passed");
        end else begin
            $display("windowed_cross_spectrum_phase_unit test failed");
        end
        $finish;
    end

    initial begin
        #(12 * 800_000);
        $display("windowed_cross_spectrum_phase_unit test failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/wcsp_pkg.sv
hdl/wcsp_cross.sv
hdl/wcsp_cordic.sv
hdl/windowed_cross_spectrum_phase_unit.sv
tb/tb_top.sv
